### rtl/core/mrc_pkg.sv
// Shared types, constants and the CRC byte update for the Modbus RTU response checker.
package mrc_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 9;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned NUM_WORDS   = 4;
   localparam int unsigned ERR_W       = 16;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned RSP_DATA_W  = 176;
   localparam int unsigned REQ_DATA_W  = 8;

   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REFL  = 16'hA001;

   // function codes
   localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;
   localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] FUNC_WRITE_MULTI  = 8'h10;
   localparam logic [7:0] FUNC_READ_WRITE   = 8'h17;

   localparam logic [LEN_W-1:0] FIXED_REPLY_LEN = 9'd8;
   localparam logic [LEN_W-1:0] HEADER_CRC_LEN  = 9'd5;
   localparam logic [LEN_W-1:0] MIN_FRAME_LEN   = 9'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_OFFSET     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAIN_OFFSET      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_OFFSET   = 2'd3;

   localparam logic [BYTE_W-1:0] SPEED_OFFSET_RST     = 8'd3;
   localparam logic [BYTE_W-1:0] DIRECTION_OFFSET_RST = 8'd7;
   localparam logic [BYTE_W-1:0] RAIN_OFFSET_RST      = 8'd11;
   localparam logic [BYTE_W-1:0] HEADING_OFFSET_RST   = 8'd15;

   typedef logic [NUM_WORDS-1:0][WORD_W-1:0] word_set_type;

   // Per-frame summary handed from the front to the back through the queue
   typedef struct packed {
      logic               crc_ok;
      logic [BYTE_W-1:0]  func_code;
      logic [LEN_W-1:0]   expected_len;
      logic [LEN_W-1:0]   received_len;
      word_set_type       words;
   } frame_sum_type;

   // Result layout, lowest bit last
   typedef struct packed {
      logic [3:0]         pad;
      logic [ERR_W-1:0]   error_count;
      logic [WORD_W-1:0]  compass;
      logic [WORD_W-1:0]  precipitation;
      logic [WORD_W-1:0]  wind_direction;
      logic [WORD_W-1:0]  wind_speed;
      logic               values_updated;
      logic [LEN_W-1:0]   received_len;
      logic [LEN_W-1:0]   expected_len;
      logic [BYTE_W-1:0]  func_code;
      logic               crc_ok;
   } rsp_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [BYTE_W-1:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/core/mrc_front.sv
// Front end: byte intake, running CRC, header decode and word capture per frame.
module mrc_front
   import mrc_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [BYTE_W-1:0]     byte_data,
   input  logic                  byte_last,
   output logic                  byte_ready,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0]     csr_data,
   output logic                  push,
   output frame_sum_type         push_data,
   input  logic                  queue_full
);

   localparam int unsigned IDX_W = $clog2(MAX_FRAME_BYTES + 1);

   logic [15:0]              crc_ff, crc_in;
   logic [IDX_W-1:0]         cnt_ff, cnt_in;
   logic [BYTE_W-1:0]        func_ff, func_in;
   logic [BYTE_W-1:0]        count_ff, count_in;
   word_set_type             words_ff, words_in;
   logic [NUM_WORDS-1:0][BYTE_W-1:0] off_ff;

   logic                     accept;
   logic                     in_frame;
   logic [LEN_W-1:0]         pos;
   logic [15:0]              crc_upd;
   logic [IDX_W-1:0]         cnt_upd;
   logic [BYTE_W-1:0]        func_upd;
   logic [BYTE_W-1:0]        count_upd;
   word_set_type             words_upd;
   logic [LEN_W-1:0]         rel;
   logic [LEN_W-1:0]         expected;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;
   assign in_frame   = cnt_ff < IDX_W'(MAX_FRAME_BYTES);
   assign pos        = LEN_W'(cnt_ff);

   always_comb begin
      crc_upd   = crc_ff;
      cnt_upd   = cnt_ff;
      func_upd  = func_ff;
      count_upd = count_ff;
      words_upd = words_ff;
      rel       = '0;
      if (in_frame) begin
         crc_upd = crc16_byte(crc_ff, byte_data);
         cnt_upd = cnt_ff + IDX_W'(1);
         if (pos == 9'd1) begin
            func_upd = byte_data;
         end
         if (pos == 9'd2) begin
            count_upd = byte_data;
         end
         // each slot takes the byte into lane order b2,b3,b0,b1
         for (int k = 0; k < NUM_WORDS; k++) begin
            rel = pos - {1'b0, off_ff[k]};
            if (pos >= {1'b0, off_ff[k]} && rel < 9'd4) begin
               case (rel[1:0])
                  2'd0:    words_upd[k][23:16] = byte_data;
                  2'd1:    words_upd[k][31:24] = byte_data;
                  2'd2:    words_upd[k][7:0]   = byte_data;
                  default: words_upd[k][15:8]  = byte_data;
               endcase
            end
         end
      end
   end

   always_comb begin
      unique case (func_upd)
         FUNC_READ_HOLDING, FUNC_READ_INPUT, FUNC_READ_WRITE:
            expected = {1'b0, count_upd} + HEADER_CRC_LEN;
         FUNC_WRITE_SINGLE, FUNC_WRITE_MULTI:
            expected = FIXED_REPLY_LEN;
         default:
            expected = '0;
      endcase
   end

   assign push                   = accept && byte_last;
   assign push_data.crc_ok       = (LEN_W'(cnt_upd) >= MIN_FRAME_LEN) && (crc_upd == 16'h0000);
   assign push_data.func_code    = func_upd;
   assign push_data.expected_len = expected;
   assign push_data.received_len = LEN_W'(cnt_upd);
   assign push_data.words        = words_upd;

   always_comb begin
      crc_in   = crc_ff;
      cnt_in   = cnt_ff;
      func_in  = func_ff;
      count_in = count_ff;
      words_in = words_ff;
      if (accept) begin
         if (byte_last) begin
            // frame done: start over
            crc_in   = CRC_INIT;
            cnt_in   = '0;
            func_in  = '0;
            count_in = '0;
            words_in = '0;
         end else begin
            crc_in   = crc_upd;
            cnt_in   = cnt_upd;
            func_in  = func_upd;
            count_in = count_upd;
            words_in = words_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         cnt_ff   <= '0;
         func_ff  <= '0;
         count_ff <= '0;
         words_ff <= '0;
         off_ff[0] <= SPEED_OFFSET_RST;
         off_ff[1] <= DIRECTION_OFFSET_RST;
         off_ff[2] <= RAIN_OFFSET_RST;
         off_ff[3] <= HEADING_OFFSET_RST;
      end else begin
         crc_ff   <= crc_in;
         cnt_ff   <= cnt_in;
         func_ff  <= func_in;
         count_ff <= count_in;
         words_ff <= words_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SPEED_OFFSET:     off_ff[0] <= csr_data;
               CSR_DIRECTION_OFFSET: off_ff[1] <= csr_data;
               CSR_RAIN_OFFSET:      off_ff[2] <= csr_data;
               CSR_HEADING_OFFSET:   off_ff[3] <= csr_data;
               default:              ;
            endcase
         end
      end
   end

endmodule

### rtl/core/mrc_queue.sv
// Two-entry queue of frame summaries between the front and the back.
module mrc_queue
   import mrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_sum_type  push_data,
   output logic           full,
   input  logic           pop,
   output frame_sum_type  pop_data,
   output logic           empty
);

   frame_sum_type  mem_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/mrc_back.sv
// Back end: word commit, error counter and the registered result stage.
module mrc_back
   import mrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  frame_sum_type          pop_data,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic [RSP_DATA_W-1:0]  rsp_data,
   input  logic                   rsp_ready
);

   word_set_type        held_ff, held_in;
   logic [ERR_W-1:0]    err_ff, err_in;
   rsp_type             rsp_ff, rsp_in;
   logic                valid_ff;
   logic                commit;

   // advance when the output stage is free or being drained
   assign pop    = !empty && (!valid_ff || rsp_ready);
   assign commit = pop_data.crc_ok && (pop_data.func_code == FUNC_READ_INPUT);

   always_comb begin
      held_in = commit ? pop_data.words : held_ff;
      err_in  = pop_data.crc_ok ? err_ff : err_ff + ERR_W'(1);

      rsp_in.pad            = '0;
      rsp_in.error_count    = err_in;
      rsp_in.compass        = held_in[3];
      rsp_in.precipitation  = held_in[2];
      rsp_in.wind_direction = held_in[1];
      rsp_in.wind_speed     = held_in[0];
      rsp_in.values_updated = commit;
      rsp_in.received_len   = pop_data.received_len;
      rsp_in.expected_len   = pop_data.expected_len;
      rsp_in.func_code      = pop_data.func_code;
      rsp_in.crc_ok         = pop_data.crc_ok;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         err_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            held_ff  <= held_in;
            err_ff   <= err_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU response checker.
// Bytes of a received response enter on req_ one per cycle while req_tready is high, in
// wire order, with tlast on the last byte. Each frame yields one result on rsp_: the front
// end folds the byte into the CRC-16 and header capture in the cycle it arrives, a
// two-entry queue holds the frame summary, and the back end commits the words, counts
// errors and drives the output register. req_tready drops only while the queue holds two
// finished frames that the result side has not drained. The user is to write offsets on
// csr_ only while no frame is open; the block itself does not enforce this.
module modbus_rtu_response_checker
   import mrc_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [7:0] rx_byte
   input  logic                   req_tlast,   // frame_end
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] crc_ok, [8:1] func_code, [17:9] expected_len, [26:18] received_len,
   // [27] values_updated, [59:28] wind_speed, [91:60] wind_direction,
   // [123:92] precipitation, [155:124] compass, [171:156] error_count, [175:172] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [BYTE_W-1:0]      csr_data
);

   logic           push;
   frame_sum_type  push_data;
   logic           queue_full;
   logic           pop;
   frame_sum_type  pop_data;
   logic           queue_empty;
   rsp_type        rsp_view;

   assign csr_ready = 1'b1;

   mrc_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .byte_last  (req_tlast),
      .byte_ready (req_tready),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   mrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   mrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (queue_empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_tdata),
      .rsp_ready (rsp_tready)
   );

   assign rsp_view = rsp_tdata;

   a_commit_needs_good_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.values_updated |-> rsp_view.crc_ok)
      else $error("words committed on a frame without a good CRC");

   a_commit_needs_func4: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.values_updated |-> rsp_view.func_code == FUNC_READ_INPUT)
      else $error("words committed for a function other than read input registers");

   a_good_crc_min_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.crc_ok |-> rsp_view.received_len >= MIN_FRAME_LEN)
      else $error("good CRC reported on a frame shorter than four bytes");

   a_error_count_on_bad: assert property (@(posedge clock) disable iff (reset)
      pop && !pop_data.crc_ok |=> rsp_view.error_count != $past(u_back.err_ff))
      else $error("error counter did not advance on a bad frame");

endmodule

### verif/modbus_rtu_response_checker_test.sv
// Self-checking testbench for the Modbus RTU response checker: frame stimulus, byte-level prediction.
module modbus_rtu_response_checker_test
   import mrc_pkg::*;
();

   localparam int unsigned FRAME_LIMIT    = 256;
   localparam int unsigned CLOCK_PERIOD   = 20;
   localparam int unsigned TIMEOUT_CYCLES = 400000;
   localparam int unsigned REPORT_LIMIT   = 10;

   // Predicts one frame summary per frame end and checks the replies in order
   class rtu_reply_scoreboard;
      logic [BYTE_W-1:0] offset_of [NUM_WORDS];
      logic [15:0]       crc_acc;
      int unsigned       byte_pos;
      logic [BYTE_W-1:0] func_seen;
      logic [BYTE_W-1:0] count_seen;
      logic [WORD_W-1:0] capture [NUM_WORDS];
      logic [WORD_W-1:0] held [NUM_WORDS];
      logic [ERR_W-1:0]  bad_frames;
      rsp_type           pending_replies [$];
      int unsigned       mismatches;
      int unsigned       replies_checked;
      int unsigned       commits_seen;

      // Reflected CRC-16, one data bit folded in per step
      function logic [15:0] crc_after(input logic [15:0] crc, input logic [BYTE_W-1:0] b);
         logic [15:0] c;
         logic        fb;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb) begin
               c = c ^ 16'hA001;
            end
         end
         return c;
      endfunction

      function void clear_frame();
         crc_acc = CRC_INIT;
         byte_pos = 0;
         func_seen = '0;
         count_seen = '0;
         foreach (capture[k]) capture[k] = '0;
      endfunction

      function void restart();
         offset_of[0] = SPEED_OFFSET_RST;
         offset_of[1] = DIRECTION_OFFSET_RST;
         offset_of[2] = RAIN_OFFSET_RST;
         offset_of[3] = HEADING_OFFSET_RST;
         foreach (held[k]) held[k] = '0;
         bad_frames = '0;
         pending_replies.delete();
         clear_frame();
      endfunction

      function void set_offset(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
         case (idx)
            CSR_SPEED_OFFSET:     offset_of[0] = val;
            CSR_DIRECTION_OFFSET: offset_of[1] = val;
            CSR_RAIN_OFFSET:      offset_of[2] = val;
            CSR_HEADING_OFFSET:   offset_of[3] = val;
            default: ;
         endcase
      endfunction

      function void take_byte(input logic [BYTE_W-1:0] b, input logic last);
         rsp_type want;
         logic    ok;
         int      rel;
         // drop everything past the frame limit
         if (byte_pos < FRAME_LIMIT) begin
            crc_acc = crc_after(crc_acc, b);
            if (byte_pos == 1) func_seen = b;
            if (byte_pos == 2) count_seen = b;
            for (int k = 0; k < NUM_WORDS; k++) begin
               rel = int'(byte_pos) - int'(offset_of[k]);
               // word order on the wire is b2:b3:b0:b1
               case (rel)
                  0: capture[k][23:16] = b;
                  1: capture[k][31:24] = b;
                  2: capture[k][7:0]   = b;
                  3: capture[k][15:8]  = b;
                  default: ;
               endcase
            end
            byte_pos++;
         end
         if (!last) return;

         ok = (byte_pos >= MIN_FRAME_LEN) && (crc_acc == 16'h0000);
         want = '0;
         want.crc_ok = ok;
         want.values_updated = ok && (func_seen == FUNC_READ_INPUT);
         if (want.values_updated) begin
            held = capture;
            commits_seen++;
         end
         if (!ok) bad_frames++;
         want.func_code = func_seen;
         case (func_seen)
            FUNC_READ_HOLDING, FUNC_READ_INPUT, FUNC_READ_WRITE:
               want.expected_len = {1'b0, count_seen} + HEADER_CRC_LEN;
            FUNC_WRITE_SINGLE, FUNC_WRITE_MULTI:
               want.expected_len = FIXED_REPLY_LEN;
            default:
               want.expected_len = '0;
         endcase
         want.received_len   = LEN_W'(byte_pos);
         want.wind_speed     = held[0];
         want.wind_direction = held[1];
         want.precipitation  = held[2];
         want.compass        = held[3];
         want.error_count    = bad_frames;
         pending_replies.push_back(want);
         clear_frame();
      endfunction

      function void compare(input string name, input logic [WORD_W-1:0] e,
                            input logic [WORD_W-1:0] g);
         if (e !== g) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Mismatch in reply %0d, %s: expected %h, got %h",
                        replies_checked, name, e, g);
            end
         end
      endfunction

      function void check_reply(input logic [RSP_DATA_W-1:0] raw);
         rsp_type got;
         rsp_type want;
         got = rsp_type'(raw);
         replies_checked++;
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Reply %0d arrived with no frame pending: %h", replies_checked, raw);
            end
            return;
         end
         want = pending_replies.pop_front();
         compare("crc_ok",         WORD_W'(want.crc_ok),         WORD_W'(got.crc_ok));
         compare("func_code",      WORD_W'(want.func_code),      WORD_W'(got.func_code));
         compare("expected_len",   WORD_W'(want.expected_len),   WORD_W'(got.expected_len));
         compare("received_len",   WORD_W'(want.received_len),   WORD_W'(got.received_len));
         compare("values_updated", WORD_W'(want.values_updated), WORD_W'(got.values_updated));
         compare("wind_speed",     want.wind_speed,              got.wind_speed);
         compare("wind_direction", want.wind_direction,          got.wind_direction);
         compare("precipitation",  want.precipitation,           got.precipitation);
         compare("compass",        want.compass,                 got.compass);
         compare("error_count",    WORD_W'(want.error_count),    WORD_W'(got.error_count));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [7:0] rx_byte
   logic                  req_tlast;   // frame_end
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // crc_ok, func_code, lengths, flag, words, error_count
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [BYTE_W-1:0]     csr_data;

   rtu_reply_scoreboard sb = new;
   logic [BYTE_W-1:0]   frame_bytes [$];
   int unsigned         bytes_sent;
   int unsigned         send_idle_pct;
   int unsigned         recv_stall_pct;
   int                  hold_left;

   modbus_rtu_response_checker #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Output side: random stalls, plus a long hold-off when one is requested
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_reply(rsp_tdata);
      end
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("Timeout with %0d replies outstanding", sb.pending_replies.size());
      $display("Verification failed");
      $finish;
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.take_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   task automatic write_offset(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_offset(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic retune(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] d,
                         input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] h);
      write_offset(CSR_SPEED_OFFSET, s);
      write_offset(CSR_DIRECTION_OFFSET, d);
      write_offset(CSR_RAIN_OFFSET, r);
      write_offset(CSR_HEADING_OFFSET, h);
   endtask

   // Drop valid, wait for every pending reply, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Append the CRC, low byte first
   function automatic void seal_frame();
      logic [15:0] c;
      c = CRC_INIT;
      foreach (frame_bytes[i]) c = sb.crc_after(c, frame_bytes[i]);
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
   endfunction

   function automatic void build_reply(input logic [BYTE_W-1:0] func, input int unsigned n);
      frame_bytes.delete();
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(func);
      if (func == FUNC_WRITE_SINGLE || func == FUNC_WRITE_MULTI) begin
         repeat (4) frame_bytes.push_back(8'($urandom));
      end else begin
         frame_bytes.push_back(8'(n));
         repeat (n) frame_bytes.push_back(8'($urandom));
      end
      seal_frame();
   endfunction

   task automatic directed_frames();
      // full read-input reply at reset offsets; the last word runs past the CRC bytes
      frame_bytes = {8'h01, FUNC_READ_INPUT, 8'd12, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h12, 8'h34,
                     8'h56, 8'h78, 8'hA5, 8'h5A, 8'h00, 8'hFF};
      seal_frame();
      send_frame();
      frame_bytes = {8'hFF, FUNC_WRITE_SINGLE, 8'h00, 8'h00, 8'hFF, 8'hFF};
      seal_frame();
      send_frame();
      // short frames, one of them with the largest byte count
      frame_bytes = {8'hFF};
      send_frame();
      frame_bytes = {8'h00, FUNC_READ_HOLDING, 8'hFF};
      send_frame();
      // read-input reply with a broken CRC
      frame_bytes = {8'h11, FUNC_READ_INPUT, 8'h00};
      seal_frame();
      frame_bytes[frame_bytes.size() - 1] ^= 8'h01;
      send_frame();
   endtask

   task automatic random_frames(input int unsigned budget);
      int unsigned       stop_at;
      int unsigned       kind;
      int unsigned       n;
      int unsigned       cut;
      logic [BYTE_W-1:0] func;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(99);
         n = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(20);
         case ($urandom_range(6))
            0:       func = FUNC_READ_HOLDING;
            1:       func = FUNC_READ_WRITE;
            2:       func = FUNC_WRITE_SINGLE;
            3:       func = FUNC_WRITE_MULTI;
            default: func = FUNC_READ_INPUT;
         endcase
         if (kind >= 55 && kind < 65) func = 8'($urandom);
         build_reply(func, n);
         if (kind >= 65 && kind < 75) begin
            // flip one bit anywhere in the frame
            cut = $urandom_range(frame_bytes.size() - 1);
            frame_bytes[cut] ^= 8'(1 << $urandom_range(7));
         end else if (kind >= 75 && kind < 87) begin
            // cut short or pad out with junk
            cut = $urandom_range(frame_bytes.size() + 3, 1);
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            while (frame_bytes.size() < cut) frame_bytes.push_back(8'($urandom));
         end else if (kind >= 87) begin
            frame_bytes.delete();
            repeat ($urandom_range(12, 1)) frame_bytes.push_back(8'($urandom));
         end
         send_frame();
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_SPEED_OFFSET;
      csr_data       = '0;
      bytes_sent     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      sb.restart();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_frames();

      // reset offsets, no idling, long output hold so the input side backs up
      settle();
      hold_left = 400;
      random_frames(200);

      settle();
      retune(8'd0, 8'd1, 8'd2, 8'd5);
      send_idle_pct = 83;
      recv_stall_pct = 0;
      random_frames(240);

      // top offset, with a good reply of the full frame limit plus trailing junk
      settle();
      retune(8'd252, 8'd250, 8'd20, 8'd9);
      send_idle_pct = 0;
      recv_stall_pct = 83;
      build_reply(FUNC_READ_INPUT, 251);
      repeat (6) frame_bytes.push_back(8'($urandom));
      send_frame();
      random_frames(100);

      settle();
      retune(8'($urandom_range(24)), 8'($urandom_range(24)), 8'($urandom_range(24)),
             8'($urandom_range(24)));
      send_idle_pct = 15;
      recv_stall_pct = 15;
      random_frames(200);

      settle();
      repeat (8) @(posedge clock);
      $display("Covered %0d bytes in %0d replies: %0d word commits, error count now %0d",
               bytes_sent, sb.replies_checked, sb.commits_seen, sb.bad_frames);
      $display("Offset sets from 0 to 252, overlong and short frames, idle and stall mixes");
      if (sb.pending_replies.size() != 0) begin
         $display("%0d predicted replies never arrived", sb.pending_replies.size());
      end
      if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
